// ===== src/dhps_pkg.sv =====
// ----------------------------------------------------------------------------
// dhps_pkg: shared types and constants for the depth/heading PD controller
// Register codes, configuration bundle, queued item format, drive saturation.
// ----------------------------------------------------------------------------
package dhps_pkg;

  // Loop and safety limits
  localparam int VERTICAL_LIMIT  = 30;
  localparam int TURN_LIMIT      = 30;
  localparam int TILT_LIMIT_CDEG = 2500;
  localparam int RATE_LIMIT_CDPS = 6000;

  // Drive limits folded into the 6-bit signed range
  localparam int VERT_HI     = (VERTICAL_LIMIT > 31) ? 31 : VERTICAL_LIMIT;
  localparam int VERT_LO_MAG = (VERTICAL_LIMIT > 32) ? 32 : VERTICAL_LIMIT;
  localparam int TURN_HI     = (TURN_LIMIT > 31) ? 31 : TURN_LIMIT;
  localparam int TURN_LO_MAG = (TURN_LIMIT > 32) ? 32 : TURN_LIMIT;

  // Angle wrap constants in centidegrees
  localparam int HALF_TURN_CDEG  = 18000;
  localparam int FULL_TURN_CDEG  = 36000;
  localparam int THREE_HALF_CDEG = 54000;
  localparam int TWO_TURN_CDEG   = 72000;

  // Gain scaling shift (gains are scaled by 2^20)
  localparam int GAIN_SHIFT = 20;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_KP    = 3'd0,
    REG_DEPTH_KD    = 3'd1,
    REG_YAW_KP      = 3'd2,
    REG_YAW_KD      = 3'd3,
    REG_DEPTH_TOL   = 3'd4,
    REG_HEADING_TOL = 3'd5,
    REG_TGT_DEPTH   = 3'd6,
    REG_TGT_HEADING = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] depth_kp;
    logic [15:0] depth_kd;
    logic [15:0] yaw_kp;
    logic [15:0] yaw_kd;
    logic [15:0] depth_tolerance_mm;
    logic [14:0] heading_tolerance_cdeg;
    logic [14:0] target_depth_mm;
    logic [15:0] target_heading_cdeg;
  } cfg_t;

  // One classified item: errors, derivatives and decision flags
  typedef struct packed {
    logic signed [16:0] depth_err;
    logic signed [17:0] depth_der;
    logic signed [15:0] head_err;
    logic signed [15:0] head_der;
    logic               stop;
    logic               ready;
  } item_t;

  // Truncated magnitude plus sign -> saturated 6-bit signed drive
  function automatic logic signed [5:0] sat_drive(input logic [15:0] mag,
                                                  input logic        neg,
                                                  input int          hi,
                                                  input int          lo_mag);
    logic [15:0] lim;
    logic [15:0] m;
    lim = neg ? 16'(lo_mag) : 16'(hi);
    m   = (mag > lim) ? lim : mag;
    return neg ? -$signed(6'(m)) : $signed(6'(m));
  endfunction

endpackage

// ===== src/dhps_front.sv =====
// ----------------------------------------------------------------------------
// dhps_front: accept sensor samples and classify them
// Forms depth/heading errors and derivatives, safety and arrival flags,
// keeps previous errors, and pushes one item per accepted sample.
// ----------------------------------------------------------------------------
module dhps_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  depth_mm,
  input  logic [15:0]         heading_cdeg,
  input  logic signed [15:0]  roll_cdeg,
  input  logic signed [14:0]  pitch_cdeg,
  input  logic signed [18:0]  yaw_rate_cdps,
  input  dhps_pkg::cfg_t      cfg,
  input  logic                q_full,
  output logic                push_valid,
  output dhps_pkg::item_t     push_item
);

  localparam logic signed [17:0] HALF  = 18'(dhps_pkg::HALF_TURN_CDEG);
  localparam logic signed [17:0] FULL  = 18'(dhps_pkg::FULL_TURN_CDEG);
  localparam logic signed [17:0] THALF = 18'(dhps_pkg::THREE_HALF_CDEG);
  localparam logic signed [17:0] TWO   = 18'(dhps_pkg::TWO_TURN_CDEG);
  localparam logic signed [19:0] TILT  = 20'(dhps_pkg::TILT_LIMIT_CDEG);
  localparam logic signed [19:0] RATE  = 20'(dhps_pkg::RATE_LIMIT_CDPS);

  logic signed [16:0] prev_depth_error;
  logic signed [15:0] prev_heading_error;

  logic               accept;
  logic signed [16:0] depth_err;
  logic signed [17:0] depth_der;
  logic signed [17:0] head_raw;
  logic signed [17:0] head_wrap;
  logic signed [15:0] head_err;
  logic signed [16:0] hd_raw;
  logic signed [16:0] hd_wrap;
  logic signed [19:0] roll_x;
  logic signed [19:0] pitch_x;
  logic signed [19:0] rate_x;
  logic signed [17:0] dtol;
  logic signed [16:0] htol;
  logic               stop;
  logic               arrived;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Depth error and derivative
  always_comb begin
    depth_err = 17'(depth_mm) - $signed({2'b00, cfg.target_depth_mm});
    depth_der = 18'(depth_err) - 18'(prev_depth_error);
  end

  // Heading error, wrapped into +-180 degrees
  always_comb begin
    head_raw = $signed({2'b00, cfg.target_heading_cdeg}) - $signed({2'b00, heading_cdeg});
    if (head_raw > THALF) begin
      head_wrap = head_raw - TWO;
    end else if (head_raw > HALF) begin
      head_wrap = head_raw - FULL;
    end else if (head_raw < -THALF) begin
      head_wrap = head_raw + TWO;
    end else if (head_raw < -HALF) begin
      head_wrap = head_raw + FULL;
    end else begin
      head_wrap = head_raw;
    end
    head_err = head_wrap[15:0];
  end

  // Heading derivative, wrapped once
  always_comb begin
    hd_raw = 17'(head_err) - 17'(prev_heading_error);
    if (hd_raw > 17'(HALF)) begin
      hd_wrap = hd_raw - 17'(FULL);
    end else if (hd_raw < -17'(HALF)) begin
      hd_wrap = hd_raw + 17'(FULL);
    end else begin
      hd_wrap = hd_raw;
    end
  end

  // Safety stop and arrival checks
  always_comb begin
    roll_x  = 20'(roll_cdeg);
    pitch_x = 20'(pitch_cdeg);
    rate_x  = 20'(yaw_rate_cdps);
    stop    = (roll_x > TILT) || (roll_x < -TILT) ||
              (pitch_x > TILT) || (pitch_x < -TILT) ||
              (rate_x > RATE) || (rate_x < -RATE);
    dtol    = $signed({2'b00, cfg.depth_tolerance_mm});
    htol    = $signed({2'b00, cfg.heading_tolerance_cdeg});
    arrived = (18'(depth_err) <= dtol) && (18'(depth_err) >= -dtol) &&
              (17'(head_err) <= htol) && (17'(head_err) >= -htol);
  end

  always_comb begin
    push_valid          = accept;
    push_item.depth_err = depth_err;
    push_item.depth_der = depth_der;
    push_item.head_err  = head_err;
    push_item.head_der  = hd_wrap[15:0];
    push_item.stop      = stop;
    push_item.ready     = !stop && arrived;
  end

  // Previous errors advance on every accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_depth_error   <= '0;
      prev_heading_error <= '0;
    end else if (accept) begin
      prev_depth_error   <= depth_err;
      prev_heading_error <= head_err;
    end
  end

endmodule

// ===== src/dhps_queue.sv =====
// ----------------------------------------------------------------------------
// dhps_queue: short FIFO between front and back
// Holds classified items so each side stalls on its own.
// ----------------------------------------------------------------------------
module dhps_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  dhps_pkg::item_t push_item,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop_en,
  output dhps_pkg::item_t pop_item
);

  dhps_pkg::item_t                 mem [dhps_pkg::QUEUE_DEPTH];
  logic [dhps_pkg::QPTR_W-1:0]     wr_ptr;
  logic [dhps_pkg::QPTR_W-1:0]     rd_ptr;
  logic [dhps_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign full      = (count == dhps_pkg::QCNT_W'(dhps_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_en && pop_valid;
  assign pop_item  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == dhps_pkg::QPTR_W'(dhps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dhps_pkg::QPTR_W'(dhps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/dhps_back.sv =====
// ----------------------------------------------------------------------------
// dhps_back: PD arithmetic and result register
// Stage 1 multiplies errors by gains; stage 2 sums, truncates toward zero,
// saturates, applies stop/arrival overrides and holds the result.
// ----------------------------------------------------------------------------
module dhps_back (
  input  logic               clk,
  input  logic               rst,
  input  dhps_pkg::cfg_t     cfg,
  input  logic               pop_valid,
  output logic               pop_en,
  input  dhps_pkg::item_t    pop_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [5:0]  vertical_drive,
  output logic signed [5:0]  turn_drive,
  output logic               ready_res,
  output logic               safety_stop
);

  // Stage 1 registers
  logic               p1_valid;
  logic signed [33:0] dp_prod;
  logic signed [34:0] dd_prod;
  logic signed [33:0] hp_prod;
  logic signed [34:0] hd_prod;
  logic               p1_stop;
  logic               p1_ready;

  logic               load_out;
  logic               load_p1;

  logic signed [35:0] d_sum;
  logic signed [35:0] h_sum;
  logic [35:0]        d_mag;
  logic [35:0]        h_mag;
  logic signed [5:0]  v_next;
  logic signed [5:0]  t_next;

  assign load_out = p1_valid && (!out_valid || !out_stall);
  assign load_p1  = !p1_valid || load_out;
  assign pop_en   = load_p1;

  // Stage 1: gain products
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (load_p1) begin
      p1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_p1 && pop_valid) begin
      dp_prod  <= $signed({1'b0, cfg.depth_kp}) * pop_item.depth_err;
      dd_prod  <= $signed({1'b0, cfg.depth_kd}) * pop_item.depth_der;
      hp_prod  <= $signed({1'b0, cfg.yaw_kp}) * 17'(pop_item.head_err);
      hd_prod  <= $signed({1'b0, cfg.yaw_kd}) * 17'(pop_item.head_der);
      p1_stop  <= pop_item.stop;
      p1_ready <= pop_item.ready;
    end
  end

  // Stage 2: sum, truncate toward zero, saturate
  always_comb begin
    d_sum  = 36'(dp_prod) + 36'(dd_prod);
    h_sum  = 36'(hp_prod) + 36'(hd_prod);
    d_mag  = d_sum[35] ? 36'(-d_sum) : 36'(d_sum);
    h_mag  = h_sum[35] ? 36'(-h_sum) : 36'(h_sum);
    v_next = dhps_pkg::sat_drive(d_mag[dhps_pkg::GAIN_SHIFT +: 16], d_sum[35],
                                 dhps_pkg::VERT_HI, dhps_pkg::VERT_LO_MAG);
    t_next = dhps_pkg::sat_drive(h_mag[dhps_pkg::GAIN_SHIFT +: 16], h_sum[35],
                                 dhps_pkg::TURN_HI, dhps_pkg::TURN_LO_MAG);
    if (p1_stop || p1_ready) begin
      v_next = '0;
      t_next = '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      vertical_drive <= v_next;
      turn_drive     <= t_next;
      ready_res      <= p1_ready;
      safety_stop    <= p1_stop;
    end
  end

endmodule

// ===== src/depth_heading_pd_with_safety.sv =====
// ----------------------------------------------------------------------------
// depth_heading_pd_with_safety: depth and heading PD controller with safety stop
// Config registers, front classifier, item queue and PD arithmetic back end.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ----------------------------------------------
//   in       in_valid / in_stall  depth_mm, heading_cdeg, roll_cdeg,
//                                 pitch_cdeg, yaw_rate_cdps
//   out      out_valid/out_stall  vertical_drive, turn_drive, ready_res,
//                                 safety_stop
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample per cycle sustained while out_stall is low; out_valid rises after the input
// transaction passes the queue, the multiply stage and then the result register.
// The queue holds two items; in_stall rises only when it is full.
// Synchronous active-high reset; valid flags, pointers and config registers return to defaults.
// cfg_ready is always high; writes go straight into the register file.
// ----------------------------------------------------------------------------
module depth_heading_pd_with_safety (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  depth_mm,
  input  logic [15:0]                         heading_cdeg,
  input  logic signed [15:0]                  roll_cdeg,
  input  logic signed [14:0]                  pitch_cdeg,
  input  logic signed [18:0]                  yaw_rate_cdps,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [5:0]                   vertical_drive,
  output logic signed [5:0]                   turn_drive,
  output logic                                ready_res,
  output logic                                safety_stop,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dhps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dhps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dhps_pkg::cfg_t  cfg;
  dhps_pkg::item_t push_item;
  dhps_pkg::item_t pop_item;
  logic            push_valid;
  logic            q_full;
  logic            pop_valid;
  logic            pop_en;

  assign cfg_ready = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_kp               <= 16'd1258;
      cfg.depth_kd               <= 16'd84;
      cfg.yaw_kp                 <= 16'd7340;
      cfg.yaw_kd                 <= 16'd1258;
      cfg.depth_tolerance_mm     <= 16'd150;
      cfg.heading_tolerance_cdeg <= 15'd500;
      cfg.target_depth_mm        <= 15'd0;
      cfg.target_heading_cdeg    <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (dhps_pkg::cfg_reg_t'(cfg_index))
        dhps_pkg::REG_DEPTH_KP:    cfg.depth_kp               <= cfg_data;
        dhps_pkg::REG_DEPTH_KD:    cfg.depth_kd               <= cfg_data;
        dhps_pkg::REG_YAW_KP:      cfg.yaw_kp                 <= cfg_data;
        dhps_pkg::REG_YAW_KD:      cfg.yaw_kd                 <= cfg_data;
        dhps_pkg::REG_DEPTH_TOL:   cfg.depth_tolerance_mm     <= cfg_data;
        dhps_pkg::REG_HEADING_TOL: cfg.heading_tolerance_cdeg <= cfg_data[14:0];
        dhps_pkg::REG_TGT_DEPTH:   cfg.target_depth_mm        <= cfg_data[14:0];
        dhps_pkg::REG_TGT_HEADING: cfg.target_heading_cdeg    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dhps_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .depth_mm      (depth_mm),
    .heading_cdeg  (heading_cdeg),
    .roll_cdeg     (roll_cdeg),
    .pitch_cdeg    (pitch_cdeg),
    .yaw_rate_cdps (yaw_rate_cdps),
    .cfg           (cfg),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_item     (push_item)
  );

  dhps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_en     (pop_en),
    .pop_item   (pop_item)
  );

  dhps_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .pop_valid      (pop_valid),
    .pop_en         (pop_en),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .vertical_drive (vertical_drive),
    .turn_drive     (turn_drive),
    .ready_res      (ready_res),
    .safety_stop    (safety_stop)
  );

endmodule
